// ===== design/crcldr_pkg.sv =====
// Package for the CRC long-division remainder core.
// Widths, CSR register indexes and the configuration struct.
// No dependencies.
package crcldr_pkg;

   localparam int MAX_DEGREE = 16;
   localparam int REM_W      = 16;
   localparam int DEG_W      = 5;
   localparam int SEL_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [REM_W-1:0] GEN_RESET = 16'h1021;
   localparam logic [DEG_W-1:0] DEG_RESET = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GENERATOR_LOW = 2'd0,
      CSR_DEGREE        = 2'd1
   } csr_idx_type;

   // Divider view of the configuration, already clamped and masked.
   typedef struct packed {
      logic [REM_W-1:0] mask;
      logic [REM_W-1:0] gen;
      logic [SEL_W-1:0] top_sel;
   } cfg_type;

endpackage

// ===== design/crcldr_if.sv =====
// Handshake interfaces for the CRC long-division remainder core.
// Depends on crcldr_pkg.
interface crcldr_req_if import crcldr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic [CNT_W-1:0]  bit_count;
   logic              last;
   modport source (output valid, data_byte, bit_count, last, input ready);
   modport sink   (input valid, data_byte, bit_count, last, output ready);
endinterface

interface crcldr_rsp_if import crcldr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REM_W-1:0] remainder;
   logic             remainder_zero;
   modport source (output valid, remainder, remainder_zero, input ready);
   modport sink   (input valid, remainder, remainder_zero, output ready);
endinterface

interface crcldr_csr_if import crcldr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/crc_long_division_remainder_core.sv =====
// CRC long-division remainder core, top level.
// Depends on crcldr_pkg, crcldr_if, crcldr_csr and crcldr_div.
//
// Divides a bit stream modulo 2 by a generator of degree 1 to 16. Each req
// word carries up to eight bits, MSB first; on the word marked last one rsp
// word gives the remainder and a zero flag, and the running remainder clears.
// A word is accepted every cycle, unless a last word waits in the input
// register behind an rsp word that is still held. A word is held in the input
// register and is divided in one pass of eight unrolled shift/XOR steps into
// the running remainder and the output register, so rsp valid rises from a
// register once the last word leaves the input register. Write the CSRs only
// while the core is idle.
module crc_long_division_remainder_core import crcldr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   crcldr_req_if.sink   req_chan,
   crcldr_rsp_if.source rsp_chan,
   crcldr_csr_if.sink   csr_chan
);

   cfg_type cfg;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic [CNT_W-1:0]  s1_count_ff;
   logic              s1_last_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              out_valid_ff, out_valid_in;
   logic [REM_W-1:0]  out_rem_ff;
   logic              out_zero_ff;
   logic [REM_W-1:0]  rem_next;
   logic              advance;
   logic              req_take;

   crcldr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   crcldr_div u_div (
      .cfg       (cfg),
      .rem_cur   (rem_ff),
      .data_byte (s1_byte_ff),
      .bit_count (s1_count_ff),
      .rem_next  (rem_next)
   );

   assign advance  = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      rem_in       = rem_ff;
      if (advance) begin
         if (s1_last_ff) begin
            rem_in       = '0;
            out_valid_in = 1'b1;
         end else begin
            rem_in = rem_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_chan.data_byte;
         s1_count_ff <= req_chan.bit_count;
         s1_last_ff  <= req_chan.last;
      end
      if (advance && s1_last_ff) begin
         out_rem_ff  <= rem_next;
         out_zero_ff <= (rem_next == '0);
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.remainder      = out_rem_ff;
   assign rsp_chan.remainder_zero = out_zero_ff;

endmodule

// ===== design/crcldr_csr.sv =====
// Configuration registers: generator and degree, with clamping of the degree.
// Depends on crcldr_pkg and crcldr_csr_if.
module crcldr_csr import crcldr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   crcldr_csr_if.sink    csr_chan,
   output cfg_type       cfg
);

   logic [REM_W-1:0] gen_ff, gen_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [DEG_W-1:0] deg_eff;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      gen_in = gen_ff;
      deg_in = deg_ff;
      if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_GENERATOR_LOW: gen_in = csr_chan.data[REM_W-1:0];
            CSR_DEGREE:        deg_in = csr_chan.data[DEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
         deg_ff <= DEG_RESET;
      end else begin
         gen_ff <= gen_in;
         deg_ff <= deg_in;
      end
   end

   always_comb begin
      priority if (deg_ff == '0) begin
         deg_eff = DEG_W'(1);
      end else if (deg_ff > DEG_W'(MAX_DEGREE)) begin
         deg_eff = DEG_W'(MAX_DEGREE);
      end else begin
         deg_eff = deg_ff;
      end
      cfg.top_sel = SEL_W'(deg_eff - DEG_W'(1));
      cfg.mask    = REM_W'((32'd1 << deg_eff) - 32'd1);
      cfg.gen     = gen_ff & cfg.mask;
   end

endmodule

// ===== design/crcldr_div.sv =====
// Eight unrolled shift/XOR division steps for one word.
// Depends on crcldr_pkg.
module crcldr_div import crcldr_pkg::*; (
   input  cfg_type           cfg,
   input  logic [REM_W-1:0]  rem_cur,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [CNT_W-1:0]  bit_count,
   output logic [REM_W-1:0]  rem_next
);

   logic [REM_W-1:0] rem_v;
   logic [REM_W-1:0] shifted;
   logic             top;

   always_comb begin
      rem_v = rem_cur & cfg.mask;
      for (int i = 0; i < BYTE_W; i++) begin
         top     = rem_v[cfg.top_sel];
         shifted = ({rem_v[REM_W-2:0], data_byte[BYTE_W-1-i]} & cfg.mask)
                   ^ (top ? cfg.gen : '0);
         if (bit_count > CNT_W'(i)) begin
            rem_v = shifted;
         end
      end
      rem_next = rem_v;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench for crc_long_division_remainder_core: directed and random words checked
// against a bit-serial modulo-2 divider kept in the bench, with random stalls on both sides.
// Depends on crcldr_pkg, crcldr_if and the core RTL.
`timescale 1ns / 100ps

module tb;
   import crcldr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 4;

   typedef struct packed {
      logic [REM_W-1:0] remainder;
      logic             remainder_zero;
   } crc_result_type;

   logic clock;
   logic reset;

   crcldr_req_if req_chan ();
   crcldr_rsp_if rsp_chan ();
   crcldr_csr_if csr_chan ();

   crc_long_division_remainder_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // divider state, mirrored from writes and accepted words
   logic [REM_W-1:0] gen_low;
   logic [DEG_W-1:0] degree_reg;
   logic [REM_W-1:0] running_rem;

   crc_result_type remainder_q[$];
   int             mismatch_count;
   int             idle_cycles;
   bit             tx_idling;
   bit             rx_idling;
   bit             hold_request;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void divide_word(input logic [BYTE_W-1:0] data,
                                       input logic [CNT_W-1:0] count,
                                       input logic last);
      int          d;
      int          n;
      logic [31:0] mask;
      logic [31:0] gen;
      logic [31:0] rem;
      logic        top;
      d = degree_reg;
      if (d < 1) d = 1;
      if (d > MAX_DEGREE) d = MAX_DEGREE;
      mask = (32'd1 << d) - 32'd1;
      gen  = {16'd0, gen_low} & mask;
      rem  = {16'd0, running_rem} & mask;
      n    = (count > 8) ? 8 : count;
      for (int i = 0; i < n; i++) begin
         top = rem[d-1];
         rem = ((rem << 1) | {31'd0, data[7-i]}) & mask;
         if (top) rem = rem ^ gen;
      end
      if (last) begin
         remainder_q.push_back({rem[REM_W-1:0], rem == 32'd0});
         running_rem = '0;
      end else begin
         running_rem = rem[REM_W-1:0];
      end
   endfunction

   task automatic send_word(input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] count,
                            input logic last);
      int gap;
      gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.bit_count <= count;
      req_chan.last      <= last;
      do @(posedge clock); while (!req_chan.ready);
      divide_word(data, count, last);
   endtask

   task automatic send_message(input int n_words);
      int               r;
      logic [CNT_W-1:0] count;
      for (int i = 0; i < n_words; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) count = 4'd0;
         else if (r == 1) count = CNT_W'($urandom_range(9, 15));
         else count = CNT_W'($urandom_range(1, 8));
         send_word(BYTE_W'($urandom_range(0, 255)), count, i == n_words - 1);
      end
   endtask

   task automatic wait_drained();
      while (remainder_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_GENERATOR_LOW: gen_low = data;
         CSR_DEGREE:        degree_reg = data[DEG_W-1:0];
         default: ;
      endcase
   endtask

   // result checker
   always @(posedge clock) begin
      crc_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (remainder_q.size() == 0) begin
            $display("%0t: unexpected word remainder=%h zero=%b", $time,
                     rsp_chan.remainder, rsp_chan.remainder_zero);
            mismatch_count++;
         end else begin
            want = remainder_q.pop_front();
            if (rsp_chan.remainder !== want.remainder) begin
               $display("%0t: remainder expected %h actual %h", $time,
                        want.remainder, rsp_chan.remainder);
               mismatch_count++;
            end
            if (rsp_chan.remainder_zero !== want.remainder_zero) begin
               $display("%0t: remainder_zero expected %b actual %b", $time,
                        want.remainder_zero, rsp_chan.remainder_zero);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_idling && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic test_directed_words();
      send_word(8'hFF, 4'd8, 1'b0);
      send_word(8'h00, 4'd0, 1'b1);
      send_word(8'hA5, 4'd15, 1'b1);
      send_word(8'h80, 4'd1, 1'b0);
      send_word(8'h7F, 4'd7, 1'b0);
      send_word(8'h01, 4'd9, 1'b1);
      send_word(8'hFF, 4'd8, 1'b1);
      send_word(8'h00, 4'd8, 1'b1);
   endtask

   task automatic test_degree_extremes();
      csr_write(CSR_DEGREE, 16'd1);
      csr_write(CSR_GENERATOR_LOW, 16'hFFFF);
      send_word(8'hFF, 4'd8, 1'b1);
      send_word(8'hB6, 4'd8, 1'b1);
      csr_write(CSR_DEGREE, 16'd0);
      send_word(8'h5A, 4'd8, 1'b1);
      csr_write(CSR_DEGREE, 16'hFFFF);
      send_word(8'hFF, 4'd8, 1'b0);
      send_word(8'hFF, 4'd8, 1'b1);
      csr_write(CSR_GENERATOR_LOW, 16'h0000);
      send_word(8'hC3, 4'd8, 1'b1);
      csr_write(CSR_SPARE_2, 16'hFFFF);
      csr_write(CSR_SPARE_3, 16'hFFFF);
      send_word(8'h96, 4'd8, 1'b1);
   endtask

   task automatic test_degree_change_mid_message();
      csr_write(CSR_GENERATOR_LOW, 16'h8005);
      csr_write(CSR_DEGREE, 16'd16);
      send_word(8'hFF, 4'd8, 1'b0);
      send_word(8'hFF, 4'd8, 1'b0);
      csr_write(CSR_DEGREE, 16'd5);
      send_word(8'h3C, 4'd8, 1'b1);
   endtask

   task automatic test_random_messages();
      int sent;
      int n;
      for (int phase = 0; phase < 14; phase++) begin
         case (phase)
            0:       csr_write(CSR_DEGREE, 16'd1);
            1:       csr_write(CSR_DEGREE, 16'd16);
            2:       csr_write(CSR_DEGREE, {11'h7FF, 5'd31});
            3:       csr_write(CSR_DEGREE, 16'd0);
            default: csr_write(CSR_DEGREE, CSR_DATA_W'($urandom_range(0, 65535)));
         endcase
         csr_write(CSR_GENERATOR_LOW, CSR_DATA_W'($urandom_range(0, 65535)));
         tx_idling = $urandom_range(0, 3) != 0;
         rx_idling = $urandom_range(0, 3) != 0;
         sent = 0;
         while (sent < 100) begin
            n = $urandom_range(1, 12);
            send_message(n);
            sent += n;
         end
      end
   endtask

   task automatic test_backpressure();
      tx_idling = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_word(BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(1, 8)), 1'b1);
   endtask

   task automatic test_final_burst();
      int sent;
      int n;
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      sent = 0;
      while (sent < 100) begin
         n = $urandom_range(1, 8);
         send_message(n);
         sent += n;
      end
   endtask

   initial begin
      mismatch_count = 0;
      idle_cycles    = 0;
      tx_idling      = 1'b1;
      rx_idling      = 1'b1;
      hold_request   = 1'b0;
      gen_low        = GEN_RESET;
      degree_reg     = DEG_RESET;
      running_rem    = '0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.bit_count <= '0;
      req_chan.last      <= 1'b0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_GENERATOR_LOW;
      csr_chan.data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_words();
      test_degree_extremes();
      test_degree_change_mid_message();
      test_random_messages();
      test_backpressure();
      test_final_burst();

      req_chan.valid <= 1'b0;
      while (remainder_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/crcldr_pkg.sv
design/crcldr_if.sv
design/crcldr_csr.sv
design/crcldr_div.sv
design/crc_long_division_remainder_core.sv
tb/tb.sv
